>>> rtl/kia_pkg.sv
// kia_pkg: shared constants, codes and control types for the keyed id allocator
// depends on nothing; imported by every module of the block
package kia_pkg;

    // table geometry
    localparam int CAPACITY  = 64;
    localparam int KEY_WIDTH = 32;
    localparam int ID_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W     = $clog2(CAPACITY + 1);

    // result id field
    localparam int OUT_ID_W = 7;
    localparam logic [OUT_ID_W-1:0] ID_NONE = {OUT_ID_W{1'b1}};

    // request function codes
    localparam logic [1:0] FUNC_LOOKUP = 2'd0;
    localparam logic [1:0] FUNC_ADD    = 2'd1;
    localparam logic [1:0] FUNC_REMOVE = 2'd2;

    // result status codes
    localparam logic [1:0] ST_FOUND = 2'd0;
    localparam logic [1:0] ST_MISS  = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // controller to datapath commands
    typedef struct packed {
        logic capture;   // latch the accepted request
        logic match;     // compare against all slots, read free stack top
        logic commit;    // resolve, update tables, load result register
    } t_cmd;

endpackage

>>> rtl/kia_ctrl.sv
// kia_ctrl: request sequencer and result valid register
// depends on kia_pkg for the command struct
module kia_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    output logic          o_valid,
    input  logic          i_stall,
    output kia_pkg::t_cmd o_cmd
);
    import kia_pkg::*;

    localparam logic [1:0] S_IDLE    = 2'd0;
    localparam logic [1:0] S_MATCH   = 2'd1;
    localparam logic [1:0] S_RESOLVE = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       r_out_valid;
    logic       w_out_free;

    // result register can take a new result when empty or being drained
    assign w_out_free = !r_out_valid || !i_stall;

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_valid;

    // commands
    always_comb begin
        o_cmd.capture = (r_state == S_IDLE) && i_valid;
        o_cmd.match   = (r_state == S_MATCH);
        o_cmd.commit  = (r_state == S_RESOLVE) && w_out_free;
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:    if (i_valid) n_state = S_MATCH;
            S_MATCH:   n_state = S_RESOLVE;
            S_RESOLVE: if (w_out_free) n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    // state and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.commit) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

>>> rtl/kia_datapath.sv
// kia_datapath: key slots with parallel match, free id stack, fresh counter,
// result register; depends on kia_pkg for geometry, codes and commands
module kia_datapath (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  kia_pkg::t_cmd                   i_cmd,
    input  logic [1:0]                      i_func,
    input  logic [kia_pkg::KEY_WIDTH-1:0]   i_key,
    output logic [kia_pkg::OUT_ID_W-1:0]    o_id,
    output logic                            o_inserted,
    output logic [1:0]                      o_status
);
    import kia_pkg::*;

    // request registers
    logic [1:0]           r_func;
    logic [KEY_WIDTH-1:0] r_key;

    // slot table
    logic [KEY_WIDTH-1:0] r_slot_key [CAPACITY];
    logic [CAPACITY-1:0]  r_slot_valid;
    logic [CAPACITY-1:0]  r_hit;

    // free stack and counters
    logic [ID_W-1:0]  r_stack [CAPACITY];
    logic [ID_W-1:0]  r_top;
    logic [CNT_W-1:0] r_depth;
    logic [CNT_W-1:0] r_fresh;
    logic [CNT_W-1:0] w_depth_m1;
    logic [ID_W-1:0]  w_top_addr;

    // resolve logic
    logic            w_hit_any;
    logic [ID_W-1:0] w_hit_id;
    logic            w_push;
    logic            w_pop;
    logic            w_take_fresh;
    logic            w_write;
    logic            w_clear;
    logic [ID_W-1:0] w_slot;
    logic [OUT_ID_W-1:0] n_id;
    logic                n_added;
    logic [1:0]          n_status;

    assign w_depth_m1 = r_depth - CNT_W'(1);
    assign w_top_addr = w_depth_m1[ID_W-1:0];

    // capture request
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_func <= i_func;
            r_key  <= i_key;
        end
    end

    // parallel match, at most one slot can hit since live keys are unique
    always_ff @(posedge i_clk) begin
        if (i_cmd.match) begin
            for (int i = 0; i < CAPACITY; i++) begin
                r_hit[i] <= r_slot_valid[i] && (r_slot_key[i] == r_key);
            end
        end
    end

    // one-hot to index, or tree
    always_comb begin
        w_hit_id = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            w_hit_id = w_hit_id | (r_hit[i] ? ID_W'(i) : '0);
        end
    end
    assign w_hit_any = |r_hit;

    // decide the outcome of the request
    always_comb begin
        w_push       = 1'b0;
        w_pop        = 1'b0;
        w_take_fresh = 1'b0;
        w_write      = 1'b0;
        w_clear      = 1'b0;
        w_slot       = w_hit_id;
        n_id         = ID_NONE;
        n_added      = 1'b0;
        n_status     = ST_MISS;
        if (w_hit_any) begin
            n_id     = OUT_ID_W'(w_hit_id);
            n_status = ST_FOUND;
            if (r_func == FUNC_REMOVE) begin
                w_clear = 1'b1;
                w_push  = (r_depth < CNT_W'(CAPACITY));
            end
        end else if (r_func == FUNC_ADD) begin
            if (r_depth != '0) begin
                // reuse most recently freed id
                w_pop   = 1'b1;
                w_write = 1'b1;
                w_slot  = r_top;
            end else if (r_fresh < CNT_W'(CAPACITY)) begin
                w_take_fresh = 1'b1;
                w_write      = 1'b1;
                w_slot       = r_fresh[ID_W-1:0];
            end else begin
                n_status = ST_FULL;
            end
            if (w_write) begin
                n_id    = OUT_ID_W'(w_slot);
                n_added = 1'b1;
            end
        end
    end

    // slot keys, no reset
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && w_write) begin
            r_slot_key[w_slot] <= r_key;
        end
    end

    // free stack memory: write on push, registered read of the top
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && w_push) begin
            r_stack[r_depth[ID_W-1:0]] <= w_hit_id;
        end
        if (i_cmd.match) begin
            r_top <= r_stack[w_top_addr];
        end
    end

    // valid bits and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_valid <= '0;
            r_depth      <= '0;
            r_fresh      <= '0;
        end else if (i_cmd.commit) begin
            if (w_clear) begin
                r_slot_valid[w_slot] <= 1'b0;
            end else if (w_write) begin
                r_slot_valid[w_slot] <= 1'b1;
            end
            if (w_push) begin
                r_depth <= r_depth + CNT_W'(1);
            end else if (w_pop) begin
                r_depth <= w_depth_m1;
            end
            if (w_take_fresh) begin
                r_fresh <= r_fresh + CNT_W'(1);
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            o_id       <= n_id;
            o_inserted <= n_added;
            o_status   <= n_status;
        end
    end

endmodule

>>> rtl/keyed_id_allocator.sv
// keyed_id_allocator: a result turns valid once its request has passed the capture,
// slot match and resolve steps; one request is in flight, so a new one is taken only
// when the sequencer has gone from match and resolve back to idle
// the next request is accepted while a result still waits in the output register;
// that request then holds in resolve until the output register drains
// synchronous active-low reset clears slot valid bits, stack depth and fresh counter
module keyed_id_allocator (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [1:0]                      i_func,
    input  logic [kia_pkg::KEY_WIDTH-1:0]   i_key,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [kia_pkg::OUT_ID_W-1:0]    o_id,
    output logic                            o_inserted,
    output logic [1:0]                      o_status
);
    import kia_pkg::*;

    t_cmd w_cmd;

    // sequencer
    kia_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_cmd   (w_cmd)
    );

    // tables and result
    kia_datapath u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_func     (i_func),
        .i_key      (i_key),
        .o_id       (o_id),
        .o_inserted (o_inserted),
        .o_status   (o_status)
    );

endmodule

>>> rtl/kia_checker.sv
// kia_checker: port-level checks for keyed_id_allocator, bound to the top level
// depends on kia_pkg for status codes and the empty id
module kia_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_valid,
    input logic                         o_stall,
    input logic                         o_valid,
    input logic                         i_stall,
    input logic [kia_pkg::OUT_ID_W-1:0] o_id,
    input logic                         o_inserted,
    input logic [1:0]                   o_status
);
    import kia_pkg::*;

    // a stalled result stays offered
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result dropped while stalled");

    // one request in flight: accept blocks the next cycle
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("second request taken while busy");

    // full table gives no id and no insert
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_FULL |-> o_id == ID_NONE && !o_inserted)
        else $error("full status with id or insert");

    // insert reports a real id and miss status
    a_added: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_inserted |-> o_status == ST_MISS && o_id != ID_NONE)
        else $error("insert with bad status or id");

    // found key has a real id
    a_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_FOUND |-> o_id != ID_NONE && !o_inserted)
        else $error("found status with bad id");

endmodule

bind keyed_id_allocator kia_checker u_kia_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_valid    (i_valid),
    .o_stall    (o_stall),
    .o_valid    (o_valid),
    .i_stall    (i_stall),
    .o_id       (o_id),
    .o_inserted (o_inserted),
    .o_status   (o_status)
);

>>> tb/tb_top.sv
// tb_top: self-checking bench for keyed_id_allocator, a directed request table then random traffic
// predicts every result with its own slot table, free stack and fresh counter; uses kia_pkg
module tb_top;
    import kia_pkg::*;

    localparam logic [1:0] FUNC_SPARE = 2'd3;
    localparam int CYCLE_LIMIT    = 400000;
    localparam int RAND_PER_PHASE = 383;
    localparam int POOL_SIZE      = 96;
    localparam int N_DIR          = 18;

    typedef struct packed {
        logic [OUT_ID_W-1:0] id;
        logic                inserted;
        logic [1:0]          status;
    } t_id_result;

    typedef struct packed {
        logic [1:0]           func;
        logic [KEY_WIDTH-1:0] key;
        logic                 has_exp;
        t_id_result           res;
    } t_dir_row;

    // dut ports, inputs driven from time zero
    logic                  i_clk   = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic [1:0]            i_func  = FUNC_LOOKUP;
    logic [KEY_WIDTH-1:0]  i_key   = '0;
    logic                  i_stall = 1'b0;
    logic                  o_stall;
    logic                  o_valid;
    logic [OUT_ID_W-1:0]   o_id;
    logic                  o_inserted;
    logic [1:0]            o_status;

    // traffic shaping and bookkeeping
    logic                  sender_idle = 1'b0;
    logic                  rcv_stall   = 1'b0;
    int                    idle_pct    = 81;
    int                    cycle_count = 0;
    int                    err_count   = 0;
    int                    sent_count  = 0;
    int                    n_added     = 0;
    int                    n_found     = 0;
    int                    n_miss      = 0;
    int                    n_full      = 0;
    logic [KEY_WIDTH-1:0]  key_pool [POOL_SIZE];
    t_id_result            pending_ids [$];
    t_id_result            want;

    // predicted allocator state
    logic [KEY_WIDTH-1:0]  pred_key  [CAPACITY];
    logic                  pred_live [CAPACITY];
    logic [ID_W-1:0]       pred_free [CAPACITY];
    int                    pred_depth;
    int                    pred_fresh;

    // directed requests: misses on an empty table, first adds, hits, removes and id reuse
    t_dir_row dir_rows [N_DIR] = '{
        '{FUNC_LOOKUP, 32'h0000_0000, 1'b1, '{ID_NONE, 1'b0, ST_MISS}},
        '{FUNC_REMOVE, 32'hFFFF_FFFF, 1'b1, '{ID_NONE, 1'b0, ST_MISS}},
        '{FUNC_SPARE,  32'h0000_0000, 1'b1, '{ID_NONE, 1'b0, ST_MISS}},
        '{FUNC_ADD,    32'h0000_0000, 1'b1, '{7'd0, 1'b1, ST_MISS}},
        '{FUNC_ADD,    32'hFFFF_FFFF, 1'b1, '{7'd1, 1'b1, ST_MISS}},
        '{FUNC_LOOKUP, 32'h0000_0000, 1'b1, '{7'd0, 1'b0, ST_FOUND}},
        '{FUNC_ADD,    32'h0000_0000, 1'b1, '{7'd0, 1'b0, ST_FOUND}},
        '{FUNC_SPARE,  32'hFFFF_FFFF, 1'b1, '{7'd1, 1'b0, ST_FOUND}},
        '{FUNC_REMOVE, 32'h0000_0000, 1'b1, '{7'd0, 1'b0, ST_FOUND}},
        '{FUNC_LOOKUP, 32'h0000_0000, 1'b0, '0},
        '{FUNC_ADD,    32'h1234_5678, 1'b0, '0},
        '{FUNC_REMOVE, 32'hFFFF_FFFF, 1'b0, '0},
        '{FUNC_REMOVE, 32'h1234_5678, 1'b0, '0},
        '{FUNC_ADD,    32'h5555_AAAA, 1'b0, '0},
        '{FUNC_ADD,    32'hAAAA_5555, 1'b0, '0},
        '{FUNC_ADD,    32'h8000_0001, 1'b0, '0},
        '{FUNC_REMOVE, 32'h7FFF_FFFE, 1'b0, '0},
        '{FUNC_LOOKUP, 32'hAAAA_5555, 1'b0, '0}
    };

    keyed_id_allocator u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_func     (i_func),
        .i_key      (i_key),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_id       (o_id),
        .o_inserted (o_inserted),
        .o_status   (o_status)
    );

    always #5 i_clk = ~i_clk;

    // match the key against live slots, then update slots, free stack and fresh counter
    function automatic t_id_result resolve_request(input logic [1:0] f,
                                                   input logic [KEY_WIDTH-1:0] k);
        int hit;
        int slot;
        int i;
        t_id_result r;
        hit = -1;
        for (i = 0; i < CAPACITY; i++)
            if (hit < 0 && pred_live[i] && pred_key[i] == k) hit = i;
        if (hit >= 0) begin
            if (f == FUNC_REMOVE) begin
                pred_live[hit] = 1'b0;
                if (pred_depth < CAPACITY) begin
                    pred_free[pred_depth] = ID_W'(hit);
                    pred_depth++;
                end
            end
            r = '{OUT_ID_W'(hit), 1'b0, ST_FOUND};
        end else if (f != FUNC_ADD) begin
            r = '{ID_NONE, 1'b0, ST_MISS};
        end else begin
            // most recently freed id first, then a fresh one
            slot = -1;
            if (pred_depth > 0) begin
                pred_depth--;
                slot = int'(pred_free[pred_depth]);
            end else if (pred_fresh < CAPACITY) begin
                slot = pred_fresh;
                pred_fresh++;
            end
            if (slot < 0) begin
                r = '{ID_NONE, 1'b0, ST_FULL};
            end else begin
                pred_key[slot]  = k;
                pred_live[slot] = 1'b1;
                r = '{OUT_ID_W'(slot), 1'b1, ST_MISS};
            end
        end
        return r;
    endfunction

    // hand one request over and queue its expected result once accepted
    task automatic send_request(input logic [1:0] f, input logic [KEY_WIDTH-1:0] k,
                                input logic has_exp, input t_id_result typed_res);
        t_id_result r;
        while (sender_idle && $urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_func  <= f;
        i_key   <= k;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        r = resolve_request(f, k);
        pending_ids.push_back(has_exp ? typed_res : r);
        sent_count++;
    endtask

    // receiver back-pressure
    always @(posedge i_clk) begin
        i_stall <= rcv_stall && ($urandom_range(99) < idle_pct);
    end

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_ids.size() == 0) begin
                $error("result with no request pending: id %0d inserted %0d status %0d",
                       o_id, o_inserted, o_status);
                err_count++;
            end else begin
                want = pending_ids.pop_front();
                if (o_id !== want.id) begin
                    $error("id: expected %0d, got %0d", want.id, o_id);
                    err_count++;
                end
                if (o_inserted !== want.inserted) begin
                    $error("inserted: expected %0d, got %0d", want.inserted, o_inserted);
                    err_count++;
                end
                if (o_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_status);
                    err_count++;
                end
                if (want.status == ST_FULL) n_full++;
                else if (want.inserted) n_added++;
                else if (want.status == ST_FOUND) n_found++;
                else n_miss++;
            end
        end
    end

    // cycle limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("run stopped at cycle %0d with %0d results outstanding",
                     cycle_count, pending_ids.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // stimulus: directed table, then four traffic phases of random requests
    initial begin
        int ph;
        int n;
        int roll;
        logic fill_mode;
        logic [1:0] f;
        logic [KEY_WIDTH-1:0] k;

        for (n = 0; n < CAPACITY; n++) begin
            pred_live[n] = 1'b0;
            pred_key[n]  = '0;
            pred_free[n] = '0;
        end
        pred_depth = 0;
        pred_fresh = 0;

        // key pool larger than the table so fill runs reach a full table
        for (n = 0; n < POOL_SIZE; n++) key_pool[n] = $urandom;
        key_pool[0] = '0;
        key_pool[1] = '1;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (ph = 0; ph < 4; ph++) begin
            @(negedge i_clk);
            sender_idle = (ph == 1) || (ph == 3);
            rcv_stall   = (ph == 2) || (ph == 3);
            idle_pct    = (ph == 3) ? 37 : 81;
            @(posedge i_clk);
            if (ph == 0)
                for (n = 0; n < N_DIR; n++)
                    send_request(dir_rows[n].func, dir_rows[n].key,
                                 dir_rows[n].has_exp, dir_rows[n].res);
            for (n = 0; n < RAND_PER_PHASE; n++) begin
                // alternate add-heavy fill runs with remove-heavy drain runs
                fill_mode = (n % 192) < 128;
                roll = $urandom_range(99);
                if (fill_mode)
                    f = (roll < 70) ? FUNC_ADD : (roll < 85) ? FUNC_LOOKUP :
                        (roll < 95) ? FUNC_REMOVE : FUNC_SPARE;
                else
                    f = (roll < 25) ? FUNC_ADD : (roll < 40) ? FUNC_LOOKUP :
                        (roll < 95) ? FUNC_REMOVE : FUNC_SPARE;
                k = ($urandom_range(99) < 82) ? key_pool[$urandom_range(POOL_SIZE - 1)]
                                              : KEY_WIDTH'($urandom);
                send_request(f, k, 1'b0, '0);
            end
            i_valid <= 1'b0;
            while (pending_ids.size() != 0) @(posedge i_clk);
        end

        repeat (8) @(posedge i_clk);
        if (pending_ids.size() != 0) begin
            $error("%0d expected results never arrived", pending_ids.size());
            err_count++;
        end
        $display("%0d requests over four traffic phases: %0d inserts, %0d hits, %0d misses,",
                 sent_count, n_added, n_found, n_miss);
        $display("%0d full-table refusals; %0d mismatches", n_full, err_count);
        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
